@@ sv/pgg_pkg.sv @@
// Shared constants and item types of the polar Gaussian generator.
package pgg_pkg;

  localparam int FIELD_W    = 32;
  localparam int LOG_FRAC   = 24;
  localparam int MANT_FRAC  = 30;
  localparam int RATIO_BITS = 32;
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  // Pipeline depths of the log and ratio units; the log result is padded to line up.
  localparam int LOG_LAT = LOG_FRAC + 5;
  localparam int DIV_LAT = RATIO_BITS + 1;
  localparam int T_PAD   = DIV_LAT - LOG_LAT;

  localparam logic [32:0] NEG_LIMIT = 33'h0_8000_0000;
  localparam logic [32:0] POS_LIMIT = 33'h0_7FFF_FFFF;

  typedef struct packed {
    logic [FIELD_W-1:0] uniform_a;
    logic [FIELD_W-1:0] uniform_b;
  } pair_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] sample;
    logic                      is_last;
  } sample_item_t;

  typedef struct packed {
    logic valid;
    logic neg_a;
    logic neg_b;
  } lane_tag_t;

endpackage

@@ sv/pgg_stream_if.sv @@
// Valid/ready stream channel carrying one item per handshake.
interface pgg_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/pgg_log.sv @@
// Pipelined -2 ln(S / 2^(2B-2)) in Q.24 by normalization and repeated squaring.
module pgg_log
  import pgg_pkg::*;
#(
  parameter int UNIFORM_BITS = 32
) (
  input  logic                                            clk,
  input  logic                                            en,
  input  logic [2*UNIFORM_BITS-1:0]                       s,
  output logic [$clog2(2*UNIFORM_BITS)+LOG_FRAC:0]        t
);

  localparam int S_W  = 2 * UNIFORM_BITS;
  localparam int LZ_W = $clog2(S_W);
  localparam int BL_W = LZ_W + LOG_FRAC;
  localparam int X_W  = MANT_FRAC + 1;
  localparam logic [BL_W+31:0] ROUND_HALF = (BL_W + 32)'(1) << 30;

  logic [LZ_W-1:0]     lz_c;
  logic [LZ_W-1:0]     lz_q;
  logic [S_W-1:0]      s_q;
  logic [S_W-1:0]      norm;
  logic [X_W-1:0]      x_st    [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] frac_st [0:LOG_FRAC];
  logic [LZ_W-1:0]     lz_st   [0:LOG_FRAC];
  logic [LZ_W-1:0]     coef;
  logic [BL_W-1:0]     big_l;
  logic [BL_W+31:0]    prod;
  logic [BL_W+31:0]    rounded;

  always_comb begin
    lz_c = '0;
    for (int i = 0; i < S_W; i++) begin
      if (s[i]) begin
        lz_c = LZ_W'(S_W - 1 - i);
      end
    end
  end

  assign norm = s_q << lz_q;

  always_ff @(posedge clk) begin
    if (en) begin
      lz_q       <= lz_c;
      s_q        <= s;
      x_st[0]    <= norm[S_W-1 -: X_W];
      frac_st[0] <= '0;
      lz_st[0]   <= lz_q;
    end
  end

  // One squaring per stage; a square at or above two yields a one bit of the fraction.
  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
    logic [2*X_W-1:0] sq;
    logic [X_W:0]     sh;

    assign sq = x_st[k] * x_st[k];
    assign sh = sq[MANT_FRAC +: X_W+1];

    always_ff @(posedge clk) begin
      if (en) begin
        x_st[k+1]    <= sh[X_W] ? sh[X_W:1] : sh[X_W-1:0];
        frac_st[k+1] <= {frac_st[k][LOG_FRAC-2:0], sh[X_W]};
        lz_st[k+1]   <= lz_st[k];
      end
    end
  end

  assign coef    = lz_st[LOG_FRAC] - LZ_W'(1);
  assign rounded = prod + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      big_l <= {coef, {LOG_FRAC{1'b0}}} - BL_W'(frac_st[LOG_FRAC]);
      prod  <= (BL_W + 32)'(big_l) * (BL_W + 32)'(LN2_Q32);
      t     <= rounded[BL_W+31:31];
    end
  end

endmodule

@@ sv/pgg_div.sv @@
// Pipelined restoring division giving floor(W^2 * 2^32 / S) for both coordinates.
module pgg_div
  import pgg_pkg::*;
#(
  parameter int UNIFORM_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  lane_tag_t                   tag_in,
  input  logic [2*UNIFORM_BITS-1:0]   s,
  input  logic [2*UNIFORM_BITS-1:0]   a2,
  input  logic [2*UNIFORM_BITS-1:0]   b2,
  output lane_tag_t                   tag_out,
  output logic [RATIO_BITS:0]         ra,
  output logic [RATIO_BITS:0]         rb
);

  localparam int S_W = 2 * UNIFORM_BITS;

  lane_tag_t           tag_st [0:DIV_LAT-1];
  logic [S_W-1:0]      den_st [0:DIV_LAT-1];
  logic [S_W-1:0]      rem_a  [0:DIV_LAT-1];
  logic [S_W-1:0]      rem_b  [0:DIV_LAT-1];
  logic [RATIO_BITS:0] quo_a  [0:DIV_LAT-1];
  logic [RATIO_BITS:0] quo_b  [0:DIV_LAT-1];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_step
    lane_tag_t           src_tag;
    logic [S_W-1:0]      src_den;
    logic [S_W-1:0]      rr_a;
    logic [S_W-1:0]      rr_b;
    logic [RATIO_BITS:0] src_qa;
    logic [RATIO_BITS:0] src_qb;
    logic                ge_a;
    logic                ge_b;

    if (k == 0) begin : g_first
      assign src_tag = tag_in;
      assign src_den = s;
      assign rr_a    = a2;
      assign rr_b    = b2;
      assign src_qa  = '0;
      assign src_qb  = '0;
    end else begin : g_next
      assign src_tag = tag_st[k-1];
      assign src_den = den_st[k-1];
      assign rr_a    = {rem_a[k-1][S_W-2:0], 1'b0};
      assign rr_b    = {rem_b[k-1][S_W-2:0], 1'b0};
      assign src_qa  = quo_a[k-1];
      assign src_qb  = quo_b[k-1];
    end

    assign ge_a = rr_a >= src_den;
    assign ge_b = rr_b >= src_den;

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_st[k] <= '0;
      end else if (en) begin
        tag_st[k] <= src_tag;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_st[k] <= src_den;
        rem_a[k]  <= ge_a ? rr_a - src_den : rr_a;
        rem_b[k]  <= ge_b ? rr_b - src_den : rr_b;
        quo_a[k]  <= {src_qa[RATIO_BITS-1:0], ge_a};
        quo_b[k]  <= {src_qb[RATIO_BITS-1:0], ge_b};
      end
    end
  end

  assign tag_out = tag_st[DIV_LAT-1];
  assign ra      = quo_a[DIV_LAT-1];
  assign rb      = quo_b[DIV_LAT-1];

endmodule

@@ sv/pgg_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, two lanes.
module pgg_sqrt
  import pgg_pkg::*;
#(
  parameter int IN_W = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  lane_tag_t            tag_in,
  input  logic [IN_W-1:0]      va,
  input  logic [IN_W-1:0]      vb,
  output lane_tag_t            tag_out,
  output logic [IN_W/2-1:0]    roota,
  output logic [IN_W/2-1:0]    rootb
);

  localparam int STEPS = IN_W / 2;

  lane_tag_t       tag_st [0:STEPS-1];
  logic [IN_W-1:0] v_a    [0:STEPS-1];
  logic [IN_W-1:0] v_b    [0:STEPS-1];
  logic [IN_W-1:0] r_a    [0:STEPS-1];
  logic [IN_W-1:0] r_b    [0:STEPS-1];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [IN_W-1:0] BITK = IN_W'(1) << (IN_W - 2 - 2 * k);
    lane_tag_t       src_tag;
    logic [IN_W-1:0] sv_a;
    logic [IN_W-1:0] sv_b;
    logic [IN_W-1:0] sr_a;
    logic [IN_W-1:0] sr_b;
    logic [IN_W-1:0] trial_a;
    logic [IN_W-1:0] trial_b;
    logic            ge_a;
    logic            ge_b;

    if (k == 0) begin : g_first
      assign src_tag = tag_in;
      assign sv_a    = va;
      assign sv_b    = vb;
      assign sr_a    = '0;
      assign sr_b    = '0;
    end else begin : g_next
      assign src_tag = tag_st[k-1];
      assign sv_a    = v_a[k-1];
      assign sv_b    = v_b[k-1];
      assign sr_a    = r_a[k-1];
      assign sr_b    = r_b[k-1];
    end

    assign trial_a = sr_a + BITK;
    assign trial_b = sr_b + BITK;
    assign ge_a    = sv_a >= trial_a;
    assign ge_b    = sv_b >= trial_b;

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_st[k] <= '0;
      end else if (en) begin
        tag_st[k] <= src_tag;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_a[k] <= ge_a ? sv_a - trial_a : sv_a;
        v_b[k] <= ge_b ? sv_b - trial_b : sv_b;
        r_a[k] <= ge_a ? (sr_a >> 1) + BITK : sr_a >> 1;
        r_b[k] <= ge_b ? (sr_b >> 1) + BITK : sr_b >> 1;
      end
    end
  end

  assign tag_out = tag_st[STEPS-1];
  assign roota   = r_a[STEPS-1][STEPS-1:0];
  assign rootb   = r_b[STEPS-1][STEPS-1:0];

endmodule

@@ sv/polar_gaussian_generator.sv @@
// Polar-method Gaussian generator: each accepted pair of uniform fractions yields either no
// sample (the point lies on or outside the unit circle or at its center) or two Gaussian
// samples on consecutive output items, first the one from uniform_b and then the one from
// uniform_a with is_last set; samples are signed fixed point with SAMPLE_FRAC_BITS fraction
// bits and saturate. The block is one pipeline that takes a new pair in every cycle in
// which its tail can move on; a kept pair occupies the output channel for two items, so
// rejected pairs pass at one pair per cycle when nothing ahead holds the pipeline, while
// kept ones are paced by the single output port. At the default widths the first sample
// of a pair passes 71 registers, the first loaded at the edge that accepts the pair (3
// front stages, 33 ratio steps, a multiply stage, one root step per pair of product bits,
// a saturation stage and the output holding register).
module polar_gaussian_generator
  import pgg_pkg::*;
#(
  parameter int UNIFORM_BITS     = 32,
  parameter int SAMPLE_FRAC_BITS = 26
) (
  input  logic         clk,
  input  logic         rst,
  pgg_stream_if.sink   pairs,
  pgg_stream_if.source samples
);

  localparam int B      = UNIFORM_BITS;
  localparam int S_W    = 2 * B;
  localparam int T_W    = $clog2(S_W) + LOG_FRAC + 1;
  localparam int PROD_W = T_W + RATIO_BITS + 1;
  localparam int IN_W   = PROD_W + (PROD_W % 2);
  localparam int RT_W   = IN_W / 2;
  localparam int SHR    = LOG_FRAC + RATIO_BITS - 2 * SAMPLE_FRAC_BITS;
  localparam logic [B-1:0] HALF = B'(1) << (B - 1);

  // The whole pipeline moves together; it holds only when its tail cannot be handed on.
  logic adv;
  logic hold_free;

  // Front stages: offsets from one half, squares, sum and the rejection test.
  logic [B-1:0]   low_a;
  logic [B-1:0]   low_b;
  logic           st1_valid;
  logic           st1_neg_a;
  logic           st1_neg_b;
  logic [B-1:0]   st1_ma;
  logic [B-1:0]   st1_mb;
  logic           st2_valid;
  logic           st2_neg_a;
  logic           st2_neg_b;
  logic [S_W-1:0] st2_a2;
  logic [S_W-1:0] st2_b2;
  logic [S_W-1:0] sum_c;
  logic           keep_c;
  lane_tag_t      st3_tag;
  logic [S_W-1:0] st3_s;
  logic [S_W-1:0] st3_a2;
  logic [S_W-1:0] st3_b2;

  // Log and ratio units run side by side; the log result is delayed to meet the ratios.
  logic [T_W-1:0]        t_log;
  logic [T_W-1:0]        t_dly [0:T_PAD-1];
  lane_tag_t             div_tag;
  logic [RATIO_BITS:0]   ra;
  logic [RATIO_BITS:0]   rb;

  lane_tag_t             mul_tag;
  logic [PROD_W-1:0]     prod_a;
  logic [PROD_W-1:0]     prod_b;

  lane_tag_t             sq_tag;
  logic [RT_W-1:0]       root_a;
  logic [RT_W-1:0]       root_b;

  logic                  fin_valid;
  logic [FIELD_W-1:0]    fin_a;
  logic [FIELD_W-1:0]    fin_b;

  // Output holding register: one kept pair, shown as two items.
  logic                  hold_valid;
  logic                  hold_phase;
  logic [FIELD_W-1:0]    hold_a;
  logic [FIELD_W-1:0]    hold_b;

  function automatic logic [FIELD_W-1:0] saturate(input logic neg,
                                                  input logic [RT_W-1:0] root);
    logic [32:0] mag;
    logic [32:0] neg_mag;
    begin
      mag = 33'(root);
      if (neg) begin
        if (mag > NEG_LIMIT) begin
          mag = NEG_LIMIT;
        end
        neg_mag = ~mag + 33'(1);
        saturate = neg_mag[FIELD_W-1:0];
      end else begin
        if (mag > POS_LIMIT) begin
          mag = POS_LIMIT;
        end
        saturate = mag[FIELD_W-1:0];
      end
    end
  endfunction

  assign hold_free   = !hold_valid || (samples.ready && hold_phase);
  assign adv         = !fin_valid || hold_free;
  assign pairs.ready = adv;

  // Only the low UNIFORM_BITS bits count. A coordinate is negative when its top bit is
  // clear, and its magnitude is then one half minus the remaining bits.
  assign low_a = {1'b0, pairs.data.uniform_a[B-2:0]};
  assign low_b = {1'b0, pairs.data.uniform_b[B-2:0]};

  always_ff @(posedge clk) begin
    if (adv) begin
      st1_neg_a <= !pairs.data.uniform_a[B-1];
      st1_neg_b <= !pairs.data.uniform_b[B-1];
      st1_ma    <= pairs.data.uniform_a[B-1] ? low_a : HALF - low_a;
      st1_mb    <= pairs.data.uniform_b[B-1] ? low_b : HALF - low_b;
      st2_neg_a <= st1_neg_a;
      st2_neg_b <= st1_neg_b;
      st2_a2    <= S_W'(st1_ma) * S_W'(st1_ma);
      st2_b2    <= S_W'(st1_mb) * S_W'(st1_mb);
      st3_s     <= sum_c;
      st3_a2    <= st2_a2;
      st3_b2    <= st2_b2;
    end
  end

  // A pair is dropped here when the radius squared is zero or reaches one.
  assign sum_c  = st2_a2 + st2_b2;
  assign keep_c = (sum_c != '0) && (sum_c[S_W-1:S_W-2] == 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
      st3_tag   <= '0;
    end else if (adv) begin
      st1_valid     <= pairs.valid;
      st2_valid     <= st1_valid;
      st3_tag.valid <= st2_valid && keep_c;
      st3_tag.neg_a <= st2_neg_a;
      st3_tag.neg_b <= st2_neg_b;
    end
  end

  pgg_log #(.UNIFORM_BITS(B)) u_log (
    .clk (clk),
    .en  (adv),
    .s   (st3_s),
    .t   (t_log)
  );

  pgg_div #(.UNIFORM_BITS(B)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .tag_in  (st3_tag),
    .s       (st3_s),
    .a2      (st3_a2),
    .b2      (st3_b2),
    .tag_out (div_tag),
    .ra      (ra),
    .rb      (rb)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      t_dly[0] <= t_log;
      for (int i = 1; i < T_PAD; i++) begin
        t_dly[i] <= t_dly[i-1];
      end
    end
  end

  // The squared sample is -2 ln(rsq) times the coordinate's share of rsq.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_a <= PROD_W'(t_dly[T_PAD-1]) * PROD_W'(ra);
      prod_b <= PROD_W'(t_dly[T_PAD-1]) * PROD_W'(rb);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_tag <= '0;
    end else if (adv) begin
      mul_tag <= div_tag;
    end
  end

  pgg_sqrt #(.IN_W(IN_W)) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .tag_in  (mul_tag),
    .va      (IN_W'(prod_a >> SHR)),
    .vb      (IN_W'(prod_b >> SHR)),
    .tag_out (sq_tag),
    .roota   (root_a),
    .rootb   (root_b)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_a <= saturate(sq_tag.neg_a, root_a);
      fin_b <= saturate(sq_tag.neg_b, root_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (adv) begin
      fin_valid <= sq_tag.valid;
    end
  end

  // The pair loads when the holding register is empty or hands over its last item.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hold_phase <= 1'b0;
    end else if (fin_valid && hold_free) begin
      hold_valid <= 1'b1;
      hold_phase <= 1'b0;
    end else if (hold_valid && samples.ready) begin
      if (!hold_phase) begin
        hold_phase <= 1'b1;
      end else begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && hold_free) begin
      hold_a <= fin_a;
      hold_b <= fin_b;
    end
  end

  assign samples.valid        = hold_valid;
  assign samples.data.sample  = hold_phase ? hold_a : hold_b;
  assign samples.data.is_last = hold_phase;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the polar Gaussian generator: directed and random pairs.
`timescale 1ns / 1ps

module tb_top;
  import pgg_pkg::*;

  // Widths of the block as instantiated here.
  localparam int U_BITS    = 32;
  localparam int F_BITS    = 26;
  localparam int N_RANDOM  = 1700;
  localparam int DRAIN_CYCLES = 150;
  localparam int IDLE_LIMIT   = 4000;
  // Items in this window are offered without any gaps; the sink has its own calm window.
  localparam int CALM_FIRST = 600;
  localparam int CALM_LAST  = 900;
  // Before this item the sender waits until every pending sample has come back.
  localparam int DRAIN_POINT = 1200;

  typedef enum logic {ROW_PREDICT, ROW_REJECT} row_kind_t;

  typedef struct {
    logic [31:0] uniform_a;
    logic [31:0] uniform_b;
    row_kind_t   kind;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pgg_stream_if #(.payload_t(pair_item_t))   pair_ch();
  pgg_stream_if #(.payload_t(sample_item_t)) sample_ch();

  polar_gaussian_generator #(
    .UNIFORM_BITS(U_BITS),
    .SAMPLE_FRAC_BITS(F_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .pairs(pair_ch.sink),
    .samples(sample_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stim_row_t    stim_q[$];
  sample_item_t gauss_expected_q[$];
  int           error_count = 0;
  int           pairs_sent = 0;
  int           pairs_kept = 0;
  int           samples_seen = 0;
  int           saturated_seen = 0;
  int           idle_cycles = 0;
  int           cycle_count = 0;
  bit           stim_done = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor. It mirrors the fixed-point pipeline of the block: the uniform
  // words are centered, the squared radius S is formed exactly, -2 ln(rsq) is
  // found from a base-2 log by repeated squaring, the share of each coordinate
  // in S comes from a long division, and the sample is the integer root of the
  // product, saturated to 32 bits.
  // ---------------------------------------------------------------------------

  // -2 ln(S / 2^62) in Q.24, for S in [1, 2^62).
  function automatic logic [63:0] neg2ln_q24(logic [63:0] s);
    int          msb;
    logic [63:0] mant;
    logic [63:0] frac;
    logic [63:0] log_inv;
    msb = 63;
    while (msb > 0 && s[msb] == 1'b0) msb--;
    if (msb >= MANT_FRAC) mant = s >> (msb - MANT_FRAC);
    else mant = s << (MANT_FRAC - msb);
    frac = '0;
    for (int i = 0; i < LOG_FRAC; i++) begin
      mant = (mant * mant) >> MANT_FRAC;
      frac = frac << 1;
      if (mant >= (64'd1 << (MANT_FRAC + 1))) begin
        mant = mant >> 1;
        frac[0] = 1'b1;
      end
    end
    log_inv = (64'(2 * U_BITS - 2 - msb) << LOG_FRAC) - frac;
    return (log_inv * 64'(LN2_Q32) + (64'd1 << 30)) >> 31;
  endfunction

  // floor(num * 2^32 / den), with num <= den.
  function automatic logic [63:0] share_q32(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = num;
    if (rem >= den) begin
      quo = 64'd1;
      rem = rem - den;
    end
    for (int i = 0; i < RATIO_BITS; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] root_u64(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bit_w;
    root = '0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= root + bit_w) begin
        v = v - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] gauss_value(bit neg, logic [63:0] coord_sq,
                                               logic [63:0] s, logic [63:0] t);
    logic [63:0] prod;
    logic [63:0] mag;
    prod = t * share_q32(coord_sq, s);
    mag = root_u64(prod >> (LOG_FRAC + RATIO_BITS - 2 * F_BITS));
    if (neg) begin
      if (mag > 64'(NEG_LIMIT)) mag = 64'(NEG_LIMIT);
      return 32'(64'd0 - mag);
    end
    if (mag > 64'(POS_LIMIT)) mag = 64'(POS_LIMIT);
    return mag[31:0];
  endfunction

  // Pushes the samples that one accepted pair causes; a rejected pair causes none.
  task automatic predict_gauss_pair(logic [31:0] ua, logic [31:0] ub);
    longint       wa;
    longint       wb;
    logic [63:0]  sq_a;
    logic [63:0]  sq_b;
    logic [63:0]  s;
    logic [63:0]  t;
    sample_item_t item;
    wa = longint'({32'd0, ua}) - (64'sd1 <<< (U_BITS - 1));
    wb = longint'({32'd0, ub}) - (64'sd1 <<< (U_BITS - 1));
    sq_a = 64'(wa * wa);
    sq_b = 64'(wb * wb);
    s = sq_a + sq_b;
    if (s == 0 || s >= (64'd1 << (2 * U_BITS - 2))) return;
    t = neg2ln_q24(s);
    pairs_kept++;
    item.sample  = gauss_value(wb < 0, sq_b, s, t);
    item.is_last = 1'b0;
    gauss_expected_q.push_back(item);
    item.sample  = gauss_value(wa < 0, sq_a, s, t);
    item.is_last = 1'b1;
    gauss_expected_q.push_back(item);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus. The directed rows cover the center of the circle, the corners
  // and edge of the square, the smallest kept radius (both signs), a zero
  // coordinate on each side, and points close to the unit circle. Rows
  // marked as rejects must give no sample at all; the rest use the predictor.
  // ---------------------------------------------------------------------------
  task automatic add_row(logic [31:0] ua, logic [31:0] ub, row_kind_t kind);
    stim_row_t row;
    row.uniform_a = ua;
    row.uniform_b = ub;
    row.kind = kind;
    stim_q.push_back(row);
  endtask

  initial begin
    logic [31:0] ua;
    logic [31:0] ub;
    add_row(32'h8000_0000, 32'h8000_0000, ROW_REJECT);   // center of the circle
    add_row(32'h0000_0000, 32'h0000_0000, ROW_REJECT);   // corner of the square
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, ROW_REJECT);
    add_row(32'h0000_0000, 32'h8000_0000, ROW_REJECT);   // exactly on the circle
    add_row(32'h8000_0000, 32'h0000_0000, ROW_REJECT);
    add_row(32'h0000_0000, 32'hFFFF_FFFF, ROW_REJECT);
    add_row(32'h8000_0001, 32'h8000_0000, ROW_PREDICT);  // tiny radius, positive
    add_row(32'h7FFF_FFFF, 32'h8000_0000, ROW_PREDICT);  // tiny radius, negative
    add_row(32'h8000_0000, 32'h8000_0001, ROW_PREDICT);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, ROW_PREDICT);
    add_row(32'h8000_0000, 32'h0000_0001, ROW_PREDICT);  // near the circle edge
    add_row(32'hFFFF_FFFF, 32'h8000_0000, ROW_PREDICT);
    add_row(32'h0000_0001, 32'h8000_0000, ROW_PREDICT);
    add_row(32'h8000_0000, 32'hFFFF_FFFF, ROW_PREDICT);
    add_row(32'hDA82_7999, 32'hDA82_7999, ROW_PREDICT);  // close to radius one
    add_row(32'h257D_8667, 32'h257D_8667, ROW_PREDICT);
    add_row(32'hC000_0000, 32'h4000_0000, ROW_PREDICT);
    add_row(32'h8000_0100, 32'h7FFF_FF00, ROW_PREDICT);
    add_row(32'h5555_5555, 32'hAAAA_AAAA, ROW_PREDICT);
    add_row(32'h8765_4321, 32'h1234_5678, ROW_PREDICT);

    // Most random pairs are plain uniforms, which land inside the circle about
    // four times in five; the rest are near the center, on the axes, or
    // edge values that are nearly always rejected.
    for (int i = 0; i < N_RANDOM; i++) begin
      ua = $urandom();
      ub = $urandom();
      case ($urandom_range(0, 19))
        0: begin
          ua = 32'h8000_0000 + $urandom_range(0, 64) - 32;
          ub = 32'h8000_0000 + $urandom_range(0, 64) - 32;
        end
        1: ua = 32'h8000_0000;
        2: ub = 32'h8000_0000;
        3: begin
          ua = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
        end
        default: ;
      endcase
      add_row(ua, ub, ROW_PREDICT);
    end
  end

  // ---------------------------------------------------------------------------
  // Pair source. Acceptance is seen at the rising edge with the values that
  // held before it; the next item is then driven once, by nonblocking writes.
  // ---------------------------------------------------------------------------
  initial begin
    int  next_idx;
    bit  offer;
    pair_ch.valid <= 1'b0;
    pair_ch.data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    next_idx = 0;
    while (!stim_done) begin
      @(posedge clk);
      if (pair_ch.valid && pair_ch.ready) begin
        if (stim_q[next_idx].kind == ROW_PREDICT) begin
          predict_gauss_pair(stim_q[next_idx].uniform_a, stim_q[next_idx].uniform_b);
        end
        pairs_sent++;
        next_idx++;
      end
      if (next_idx >= stim_q.size()) begin
        stim_done = 1'b1;
        pair_ch.valid <= 1'b0;
      end else if (pair_ch.valid && !(pair_ch.ready)) begin
        // An offered item stays put until it is taken.
      end else begin
        offer = ($urandom_range(0, 99) >= 16) ||
                (next_idx >= CALM_FIRST && next_idx < CALM_LAST);
        if (next_idx == DRAIN_POINT && gauss_expected_q.size() != 0) offer = 1'b0;
        pair_ch.valid <= offer;
        pair_ch.data  <= '{uniform_a: stim_q[next_idx].uniform_a,
                           uniform_b: stim_q[next_idx].uniform_b};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample sink and checker. Every accepted sample must match the oldest
  // expectation in both fields.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sample_item_t got;
    sample_item_t want;
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready) begin
        got = sample_ch.data;
        samples_seen++;
        if (got.sample == 32'sh7FFF_FFFF || got.sample == 32'sh8000_0000) saturated_seen++;
        if (gauss_expected_q.size() == 0) begin
          $display("%0t: sample with none expected: sample=%0d is_last=%0b",
                   $time, got.sample, got.is_last);
          error_count++;
        end else begin
          want = gauss_expected_q.pop_front();
          if (got.sample !== want.sample) begin
            $display("%0t: sample mismatch: expected %0d, actual %0d",
                     $time, want.sample, got.sample);
            error_count++;
          end
          if (got.is_last !== want.is_last) begin
            $display("%0t: is_last mismatch: expected %0b, actual %0b",
                     $time, want.is_last, got.is_last);
            error_count++;
          end
        end
      end
      sample_ch.ready <= ($urandom_range(0, 99) >= 16) ||
                         (cycle_count >= 3000 && cycle_count < 4500);
    end else begin
      sample_ch.ready <= 1'b0;
    end
  end

  // Watchdog: cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (pair_ch.valid && pair_ch.ready) || (sample_ch.valid && sample_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d samples outstanding",
                 $time, IDLE_LIMIT, gauss_expected_q.size());
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // End of run: drain, let the pipeline settle, then report.
  initial begin
    wait (stim_done);
    while (gauss_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (gauss_expected_q.size() != 0) begin
      $display("%0t: %0d expected samples never arrived", $time, gauss_expected_q.size());
      error_count++;
    end
    $display("Sent %0d pairs, %0d inside the circle, %0d samples checked.",
             pairs_sent, pairs_kept, samples_seen);
    $display("Saturated samples seen: %0d; mismatches: %0d.", saturated_seen, error_count);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/pgg_pkg.sv
sv/pgg_stream_if.sv
sv/pgg_log.sv
sv/pgg_div.sv
sv/pgg_sqrt.sv
sv/polar_gaussian_generator.sv
tb/tb_top.sv
